/* sv/hue_fourier_gray_mapping_macros.svh */
// Assertion macros for the hue Fourier gray mapping block.
`ifndef HUE_FOURIER_GRAY_MAPPING_MACROS_SVH
`define HUE_FOURIER_GRAY_MAPPING_MACROS_SVH
`ifndef SYNTHESIS
`define HFG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HFG_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);
`else
`define HFG_ASSERT(label, clk, rst, prop, msg)
`define HFG_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)
`endif
`endif

/* sv/hfg_pkg.sv */
// Shared types, constants and sine table builder for the hue Fourier gray mapping.
`default_nettype none
package hfg_pkg;

   localparam int L_W       = 15;
   localparam int C_W       = 16;
   localparam int H_W       = 16;
   localparam int COEF_W    = 24;
   localparam int TRIG_W    = 16;
   localparam int PROD_W    = COEF_W + TRIG_W;
   localparam int F_W       = 42;
   localparam int F_LO_W    = 21;
   localparam int F_HI_W    = F_W - F_LO_W;
   localparam int MUL_W     = 58;
   localparam int ROUND_SH  = 30;
   localparam int ROUND_W   = MUL_W - ROUND_SH;
   localparam int SUM_W     = ROUND_W + 1;
   localparam int GRAY_W    = 19;
   localparam int C0_SHIFT  = 14;
   localparam int PAIRS     = 4;
   localparam int ENTRY_W   = 15;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PAIR_1   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_2   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_3   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_4   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONSTANT = 3'd4;

   localparam logic signed [GRAY_W-1:0] GRAY_MAX = 19'sh3FFFF;
   localparam logic signed [GRAY_W-1:0] GRAY_MIN = 19'sh40000;

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   typedef struct packed {
      logic signed [COEF_W-1:0] cos_coef;
      logic signed [COEF_W-1:0] sin_coef;
   } harmonic_pair_type;

   typedef struct packed {
      logic [L_W-1:0]        lightness;
      logic [C_W-1:0]        chroma;
      logic [H_W-1:0]        hue_angle;
      logic signed [F_W-1:0] weight;
   } cell_link_type;

   // quarter-wave sine entry j, Q1.14, Taylor series in Q.30
   function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned j,
                                                     input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (64'(j) * PI_HALF_Q30) >> qbits;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s  = (((x * t) >> 30) + (64'd1 << 15)) >> 16;
      if (s > 64'd16384) begin
         s = 64'd16384;
      end
      return ENTRY_W'(s);
   endfunction

endpackage
`default_nettype wire

/* sv/hfg_req_if.sv */
// Pixel input channel: valid/ready with one LCh pixel per beat.
`default_nettype none
interface hfg_req_if;
   logic                          valid;
   logic                          ready;
   logic [hfg_pkg::L_W-1:0]       lightness;
   logic [hfg_pkg::C_W-1:0]       chroma;
   logic [hfg_pkg::H_W-1:0]       hue_angle;

   modport source (output valid, output lightness, output chroma, output hue_angle,
                   input ready);
   modport sink (input valid, input lightness, input chroma, input hue_angle,
                 output ready);
endinterface
`default_nettype wire

/* sv/hfg_rsp_if.sv */
// Gray result channel: valid/ready with one gray value per beat.
`default_nettype none
interface hfg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hfg_pkg::GRAY_W-1:0]   gray_value;
   logic                                clipped;

   modport source (output valid, output gray_value, output clipped, input ready);
   modport sink (input valid, input gray_value, input clipped, output ready);
endinterface
`default_nettype wire

/* sv/hfg_cell.sv */
// One harmonic cell: sine/cosine lookup, coefficient products and weight accumulation.
`default_nettype none
module hfg_cell #(
   parameter int HARMONIC        = 1,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  hfg_pkg::cell_link_type     up_link,
   input  hfg_pkg::harmonic_pair_type coefs,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output hfg_pkg::cell_link_type     dn_link
);

   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QLEN  = 1 << QBITS;
   localparam logic [QBITS:0] QLEN_IDX = (QBITS + 1)'(QLEN);

   logic [hfg_pkg::ENTRY_W-1:0] quarter_sine [QLEN + 1];

   for (genvar j = 0; j <= QLEN; j++) begin : g_table
      assign quarter_sine[j] = hfg_pkg::sine_entry(j, QBITS);
   end

   logic [hfg_pkg::H_W-1:0]           phase [2];
   logic signed [hfg_pkg::TRIG_W-1:0] trig_in [2];

   assign phase[0] = hfg_pkg::H_W'(up_link.hue_angle * hfg_pkg::H_W'(HARMONIC));
   assign phase[1] = phase[0] + hfg_pkg::H_W'(1 << (hfg_pkg::H_W - 2));

   always_comb begin
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [QBITS-1:0]           pos;
      logic [QBITS:0]             addr;
      logic [hfg_pkg::TRIG_W-1:0] mag;
      for (int i = 0; i < 2; i++) begin
         idx  = phase[i][hfg_pkg::H_W-1 -: SINE_TABLE_BITS];
         pos  = idx[QBITS-1:0];
         addr = idx[QBITS] ? (QLEN_IDX - {1'b0, pos}) : {1'b0, pos};
         mag  = {1'b0, quarter_sine[addr]};
         trig_in[i] = idx[SINE_TABLE_BITS-1] ? -$signed(mag) : $signed(mag);
      end
   end

   logic load1;
   logic load2;
   logic load3;
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;

   assign load3    = !v3_ff || dn_ready;
   assign load2    = !v2_ff || load3;
   assign load1    = !v1_ff || load2;
   assign up_ready = load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= up_valid;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
      end
   end

   hfg_pkg::cell_link_type            link1_ff;
   hfg_pkg::cell_link_type            link2_ff;
   hfg_pkg::cell_link_type            link3_ff;
   logic signed [hfg_pkg::TRIG_W-1:0] sin_ff;
   logic signed [hfg_pkg::TRIG_W-1:0] cos_ff;
   logic signed [hfg_pkg::PROD_W-1:0] pa_ff;
   logic signed [hfg_pkg::PROD_W-1:0] pb_ff;
   logic signed [hfg_pkg::PROD_W-1:0] pa_in;
   logic signed [hfg_pkg::PROD_W-1:0] pb_in;
   logic signed [hfg_pkg::F_W-1:0]    weight_in;

   assign pa_in     = coefs.cos_coef * cos_ff;
   assign pb_in     = coefs.sin_coef * sin_ff;
   assign weight_in = link2_ff.weight + hfg_pkg::F_W'(pa_ff) + hfg_pkg::F_W'(pb_ff);

   always_ff @(posedge clock) begin
      if (load1) begin
         link1_ff <= up_link;
         sin_ff   <= trig_in[0];
         cos_ff   <= trig_in[1];
      end
      if (load2) begin
         link2_ff <= link1_ff;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
      end
      if (load3) begin
         link3_ff <= '{lightness: link2_ff.lightness, chroma: link2_ff.chroma,
                       hue_angle: link2_ff.hue_angle, weight: weight_in};
      end
   end

   assign dn_valid = v3_ff;
   assign dn_link  = link3_ff;

endmodule
`default_nettype wire

/* sv/hfg_gray_stage.sv */
// Tail of the chain: weight times chroma, Q.30 rounding, lightness add and saturation.
`default_nettype none
module hfg_gray_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  hfg_pkg::cell_link_type            up_link,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic signed [hfg_pkg::GRAY_W-1:0] gray_value,
   output logic                              clipped
);

   localparam int PLO_W = hfg_pkg::F_LO_W + hfg_pkg::C_W;
   localparam int PHI_W = hfg_pkg::F_HI_W + hfg_pkg::C_W + 1;
   localparam logic signed [hfg_pkg::MUL_W-1:0] HALF_LSB =
      hfg_pkg::MUL_W'(64'd1 << (hfg_pkg::ROUND_SH - 1));
   localparam logic signed [hfg_pkg::SUM_W-1:0] SUM_MAX = hfg_pkg::SUM_W'(hfg_pkg::GRAY_MAX);
   localparam logic signed [hfg_pkg::SUM_W-1:0] SUM_MIN = hfg_pkg::SUM_W'(hfg_pkg::GRAY_MIN);

   logic load1;
   logic load2;
   logic load3;
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;

   assign load3    = !v3_ff || dn_ready;
   assign load2    = !v2_ff || load3;
   assign load1    = !v1_ff || load2;
   assign up_ready = load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= up_valid;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
      end
   end

   logic [PLO_W-1:0]                   plo_in;
   logic signed [PHI_W-1:0]            phi_in;
   logic [PLO_W-1:0]                   plo_ff;
   logic signed [PHI_W-1:0]            phi_ff;
   logic [hfg_pkg::L_W-1:0]            l1_ff;
   logic [hfg_pkg::L_W-1:0]            l2_ff;
   logic signed [hfg_pkg::MUL_W-1:0]   prod;
   logic signed [hfg_pkg::ROUND_W-1:0] round_in;
   logic signed [hfg_pkg::ROUND_W-1:0] round_ff;
   logic signed [hfg_pkg::SUM_W-1:0]   sum;
   logic signed [hfg_pkg::GRAY_W-1:0]  gray_in;
   logic                               clip_in;
   logic signed [hfg_pkg::GRAY_W-1:0]  gray_ff;
   logic                               clip_ff;

   // split the weight so that each product stays narrow
   assign plo_in = PLO_W'(up_link.weight[hfg_pkg::F_LO_W-1:0]) * PLO_W'(up_link.chroma);
   assign phi_in = $signed(up_link.weight[hfg_pkg::F_W-1:hfg_pkg::F_LO_W])
                   * $signed({1'b0, up_link.chroma});

   assign prod = (hfg_pkg::MUL_W'(phi_ff) <<< hfg_pkg::F_LO_W)
                 + $signed(hfg_pkg::MUL_W'(plo_ff)) + HALF_LSB;
   assign round_in = prod[hfg_pkg::MUL_W-1:hfg_pkg::ROUND_SH];

   always_comb begin
      sum = hfg_pkg::SUM_W'(round_ff) + $signed(hfg_pkg::SUM_W'(l2_ff));
      if (sum > SUM_MAX) begin
         gray_in = hfg_pkg::GRAY_MAX;
         clip_in = 1'b1;
      end else if (sum < SUM_MIN) begin
         gray_in = hfg_pkg::GRAY_MIN;
         clip_in = 1'b1;
      end else begin
         gray_in = sum[hfg_pkg::GRAY_W-1:0];
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         l1_ff  <= up_link.lightness;
      end
      if (load2) begin
         round_ff <= round_in;
         l2_ff    <= l1_ff;
      end
      if (load3) begin
         gray_ff <= gray_in;
         clip_ff <= clip_in;
      end
   end

   assign dn_valid   = v3_ff;
   assign gray_value = gray_ff;
   assign clipped    = clip_ff;

endmodule
`default_nettype wire

/* sv/hue_fourier_gray_mapping.sv */
// Top level of the hue Fourier gray mapping: register file, harmonic cell chain and tail.
//
// Maps one LCh pixel a clock to gray = L + f(h)*C while the output takes results,
// where f(h) is a Fourier series of HARMONICS cosine/sine pairs plus a constant,
// all signed Q7.16 held in the register file (pairs at byte addresses 0, 8, 16,
// 24, constant at 32). One pixel is taken every cycle while the output is not
// stalled; each harmonic cell adds three pipeline stages and the tail another
// three. The stage valid bits let an item enter while a finished result waits to
// be taken; intake stops only once every stage is full.
`default_nettype none
`include "hue_fourier_gray_mapping_macros.svh"
module hue_fourier_gray_mapping #(
   parameter int HARMONICS       = 4,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   hfg_req_if.sink                            req_ch,
   hfg_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hfg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hfg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hfg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   // register file
   hfg_pkg::harmonic_pair_type         pair_ff [hfg_pkg::PAIRS];
   logic signed [hfg_pkg::COEF_W-1:0]  constant_ff;
   logic [hfg_pkg::CSR_IDX_W-1:0]      csr_idx;
   logic                               csr_write;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[hfg_pkg::CSR_ADDR_W-1:hfg_pkg::CSR_ADDR_W-hfg_pkg::CSR_IDX_W];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hfg_pkg::PAIRS; i++) begin
            pair_ff[i] <= '0;
         end
         constant_ff <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            hfg_pkg::REG_PAIR_1: begin
               pair_ff[0] <= csr_pwdata[2*hfg_pkg::COEF_W-1:0];
            end
            hfg_pkg::REG_PAIR_2: begin
               pair_ff[1] <= csr_pwdata[2*hfg_pkg::COEF_W-1:0];
            end
            hfg_pkg::REG_PAIR_3: begin
               pair_ff[2] <= csr_pwdata[2*hfg_pkg::COEF_W-1:0];
            end
            hfg_pkg::REG_PAIR_4: begin
               pair_ff[3] <= csr_pwdata[2*hfg_pkg::COEF_W-1:0];
            end
            hfg_pkg::REG_CONSTANT: begin
               constant_ff <= csr_pwdata[hfg_pkg::COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         hfg_pkg::REG_PAIR_1:   csr_prdata = hfg_pkg::CSR_DATA_W'(pair_ff[0]);
         hfg_pkg::REG_PAIR_2:   csr_prdata = hfg_pkg::CSR_DATA_W'(pair_ff[1]);
         hfg_pkg::REG_PAIR_3:   csr_prdata = hfg_pkg::CSR_DATA_W'(pair_ff[2]);
         hfg_pkg::REG_PAIR_4:   csr_prdata = hfg_pkg::CSR_DATA_W'(pair_ff[3]);
         hfg_pkg::REG_CONSTANT: csr_prdata = hfg_pkg::CSR_DATA_W'(constant_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // cell chain
   logic                   link_valid [HARMONICS + 1];
   logic                   link_ready [HARMONICS + 1];
   hfg_pkg::cell_link_type link       [HARMONICS + 1];

   assign link_valid[0]       = req_ch.valid;
   assign req_ch.ready        = link_ready[0];
   assign link[0].lightness   = req_ch.lightness;
   assign link[0].chroma      = req_ch.chroma;
   assign link[0].hue_angle   = req_ch.hue_angle;
   assign link[0].weight      = hfg_pkg::F_W'(constant_ff) <<< hfg_pkg::C0_SHIFT;

   for (genvar g = 0; g < HARMONICS; g++) begin : g_cell
      hfg_cell #(
         .HARMONIC        (g + 1),
         .SINE_TABLE_BITS (SINE_TABLE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[g]),
         .up_ready (link_ready[g]),
         .up_link  (link[g]),
         .coefs    (pair_ff[g]),
         .dn_valid (link_valid[g + 1]),
         .dn_ready (link_ready[g + 1]),
         .dn_link  (link[g + 1])
      );
   end

   hfg_gray_stage u_gray (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (link_valid[HARMONICS]),
      .up_ready   (link_ready[HARMONICS]),
      .up_link    (link[HARMONICS]),
      .dn_valid   (rsp_ch.valid),
      .dn_ready   (rsp_ch.ready),
      .gray_value (rsp_ch.gray_value),
      .clipped    (rsp_ch.clipped)
   );

   `HFG_ASSERT(a_clip_at_limit, clock, reset, (rsp_ch.valid && rsp_ch.clipped) |-> (rsp_ch.gray_value == hfg_pkg::GRAY_MAX || rsp_ch.gray_value == hfg_pkg::GRAY_MIN), "clipped beat not at a limit")
   `HFG_ASSERT(a_intake_stall, clock, reset, !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready), "intake stalled without an output stall")
   `HFG_ASSERT_NEXT(a_constant_write, clock, reset, csr_write && csr_idx == hfg_pkg::REG_CONSTANT, constant_ff == $signed($past(csr_pwdata[hfg_pkg::COEF_W-1:0])), "constant term write lost")

endmodule
`default_nettype wire
